FILE: rtl/segment_box_crossing_test_macros.svh
// Assertion macros shared by the RTL of the segment versus box crossing test.
// All of them sample on clk_i; the first one is disabled while rst_ni is low.
`ifndef SEGMENT_BOX_CROSSING_TEST_MACROS_SVH
`define SEGMENT_BOX_CROSSING_TEST_MACROS_SVH

`define SBCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SBCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/sbct_pkg.sv
package sbct_pkg;

  localparam int CoordBitsDefault = 24;

  // Bit positions of the edges in edge_hits.
  localparam int EdgeCount  = 4;
  localparam int EdgeTop    = 0;
  localparam int EdgeLeft   = 1;
  localparam int EdgeBottom = 2;
  localparam int EdgeRight  = 3;

endpackage

FILE: rtl/sbct_stream_if.sv
interface sbct_query_if #(
  parameter int CoordBits = sbct_pkg::CoordBitsDefault
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] start_x;
  logic signed [CoordBits-1:0] start_y;
  logic signed [CoordBits-1:0] end_x;
  logic signed [CoordBits-1:0] end_y;
  logic signed [CoordBits-1:0] box_left;
  logic signed [CoordBits-1:0] box_top;
  logic        [CoordBits-2:0] box_width;
  logic        [CoordBits-2:0] box_height;

  modport source (
    output valid, start_x, start_y, end_x, end_y, box_left, box_top, box_width, box_height,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y, box_left, box_top, box_width, box_height,
    output ready
  );
endinterface

interface sbct_result_if;
  logic                              valid;
  logic                              ready;
  logic [sbct_pkg::EdgeCount-1:0]    edge_hits;
  logic                              blocked;

  modport source (
    output valid, edge_hits, blocked,
    input  ready
  );

  modport sink (
    input  valid, edge_hits, blocked,
    output ready
  );
endinterface

FILE: rtl/segment_box_crossing_test.sv
// Channel   Dir  Interface        Payload
// query_i   in   sbct_query_if    start/end point, box left, top, width, height
// result_o  out  sbct_result_if   edge_hits, blocked
//
// Five register stages: input, differences, products, sums, result. A beat
// accepted on query_i passes through them in that order to result_o.
// One query is accepted every cycle unless a stall at result_o has filled the
// pipeline; the four multipliers of the product stage are each used once per query.
// Reset clears only the stage valid bits. Each stage has its own ready, so a
// stall at result_o holds only the stages behind a full one and bubbles close up.
`include "segment_box_crossing_test_macros.svh"

module segment_box_crossing_test #(
  parameter int CoordBits = sbct_pkg::CoordBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  sbct_query_if.sink     query_i,
  sbct_result_if.source  result_o
);
  import sbct_pkg::*;

  localparam int NumStages = 5;
  localparam int DW = CoordBits + 1;      // plain coordinate differences
  localparam int EW = CoordBits + 2;      // differences with a box extent folded in
  localparam int PW = 2 * CoordBits + 2;  // products
  localparam int SW = 2 * CoordBits + 4;  // sums of products

  // Inclusive parametric bound test: num / den lies in [0, 1], den nonzero.
  function automatic logic range_ok_e(logic signed [EW-1:0] num, logic signed [EW-1:0] den);
    logic res;
    if (den > 0) begin
      res = (num >= 0) && (num <= den);
    end else if (den < 0) begin
      res = (num <= 0) && (num >= den);
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

  function automatic logic range_ok_s(logic signed [SW-1:0] num, logic signed [SW-1:0] den);
    logic res;
    if (den > 0) begin
      res = (num >= 0) && (num <= den);
    end else if (den < 0) begin
      res = (num <= 0) && (num >= den);
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

  // Handshake chain
  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] stage_in_valid;
  logic [NumStages:0]   adv;

  always_comb begin
    adv[NumStages] = result_o.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    stage_in_valid = {valid_q[NumStages-2:0], query_i.valid};
    valid_d = (adv[NumStages-1:0] & stage_in_valid) | (~adv[NumStages-1:0] & valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign query_i.ready = adv[0];

  // Stage 0: input register
  logic signed [CoordBits-1:0] x1_q, y1_q, x2_q, y2_q, left_q, top_q;
  logic        [CoordBits-2:0] wid_q, hgt_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      x1_q   <= query_i.start_x;
      y1_q   <= query_i.start_y;
      x2_q   <= query_i.end_x;
      y2_q   <= query_i.end_y;
      left_q <= query_i.box_left;
      top_q  <= query_i.box_top;
      wid_q  <= query_i.box_width;
      hgt_q  <= query_i.box_height;
    end
  end

  // Stage 1: differences. dyb is bottom minus y1, dxr is right minus x1.
  logic signed [CoordBits-1:0] wid_s, hgt_s;
  logic signed [DW-1:0]        sx_d, sy_d, dxl_d, dyt_d;
  logic signed [EW-1:0]        dyb_d, dxr_d;
  logic signed [DW-1:0]        sx_q, sy_q, dxl_q, dyt_q;
  logic signed [EW-1:0]        dyb_q, dxr_q;
  logic signed [CoordBits-1:0] wid1_q, hgt1_q;

  always_comb begin
    wid_s = signed'(CoordBits'(wid_q));
    hgt_s = signed'(CoordBits'(hgt_q));
    sx_d  = DW'(x2_q) - DW'(x1_q);
    sy_d  = DW'(y2_q) - DW'(y1_q);
    dxl_d = DW'(left_q) - DW'(x1_q);
    dyt_d = DW'(top_q) - DW'(y1_q);
    dyb_d = EW'(top_q) - EW'(hgt_s) - EW'(y1_q);
    dxr_d = EW'(left_q) + EW'(wid_s) - EW'(x1_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      dxl_q  <= dxl_d;
      dyt_q  <= dyt_d;
      dyb_q  <= dyb_d;
      dxr_q  <= dxr_d;
      wid1_q <= wid_s;
      hgt1_q <= hgt_s;
    end
  end

  // Stage 2: products, and the bound on the segment parameter for each edge.
  // The box extent is a positive common factor of that bound and cancels.
  logic signed [PW-1:0]  prod_a_d, prod_b_d, prod_c_d, prod_e_d;
  logic signed [PW-1:0]  prod_a_q, prod_b_q, prod_c_q, prod_e_q;
  logic [EdgeCount-1:0]  seg_ok_d, seg_ok2_q;

  always_comb begin
    prod_a_d = sx_q * dyt_q;
    prod_b_d = sy_q * dxl_q;
    prod_c_d = sy_q * wid1_q;
    prod_e_d = sx_q * hgt1_q;
    seg_ok_d[EdgeTop]    = range_ok_e(EW'(dyt_q), EW'(sy_q));
    seg_ok_d[EdgeLeft]   = range_ok_e(EW'(dxl_q), EW'(sx_q));
    seg_ok_d[EdgeBottom] = range_ok_e(dyb_q, EW'(sy_q));
    seg_ok_d[EdgeRight]  = range_ok_e(dxr_q, EW'(sx_q));
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      prod_a_q  <= prod_a_d;
      prod_b_q  <= prod_b_d;
      prod_c_q  <= prod_c_d;
      prod_e_q  <= prod_e_d;
      seg_ok2_q <= seg_ok_d;
    end
  end

  // Stage 3: edge parameter numerators, sign-adjusted so that the top and
  // bottom edges compare against sy*W and the left and right against sx*H.
  logic signed [SW-1:0] num_tl_d, num_b_d, num_r_d;
  logic signed [SW-1:0] num_tl_q, num_b_q, num_r_q, den_h_q, den_v_q;
  logic [EdgeCount-1:0] seg_ok3_q;

  always_comb begin
    num_tl_d = SW'(prod_a_q) - SW'(prod_b_q);
    num_b_d  = SW'(prod_a_q) - SW'(prod_b_q) - SW'(prod_e_q);
    num_r_d  = SW'(prod_c_q) + SW'(prod_e_q) - SW'(prod_a_q) + SW'(prod_b_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      num_tl_q  <= num_tl_d;
      num_b_q   <= num_b_d;
      num_r_q   <= num_r_d;
      den_h_q   <= SW'(prod_c_q);
      den_v_q   <= SW'(prod_e_q);
      seg_ok3_q <= seg_ok2_q;
    end
  end

  // Stage 4: result register
  logic [EdgeCount-1:0] hits_d, hits_q;
  logic                 blocked_q;

  always_comb begin
    hits_d[EdgeTop]    = seg_ok3_q[EdgeTop]    && range_ok_s(num_tl_q, den_h_q);
    hits_d[EdgeLeft]   = seg_ok3_q[EdgeLeft]   && range_ok_s(num_tl_q, den_v_q);
    hits_d[EdgeBottom] = seg_ok3_q[EdgeBottom] && range_ok_s(num_b_q, den_h_q);
    hits_d[EdgeRight]  = seg_ok3_q[EdgeRight]  && range_ok_s(num_r_q, den_v_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      hits_q    <= hits_d;
      blocked_q <= |hits_d;
    end
  end

  assign result_o.valid     = valid_q[NumStages-1];
  assign result_o.edge_hits = hits_q;
  assign result_o.blocked   = blocked_q;

  // Input back-pressure only comes from a pipeline that is full to the output.
  `SBCT_ASSERT(full_when_stalled, !query_i.ready |-> (&valid_q && !result_o.ready), "input stalled with a free stage")
  // A beat leaving the input stage lands in the next stage.
  `SBCT_ASSERT(beat_moves_on, (valid_q[0] && adv[1]) |=> valid_q[1], "beat lost between stages")
  `SBCT_ASSERT_ALWAYS(empty_in_reset, !rst_ni |=> (valid_q == '0), "stage valid set during reset")

endmodule

FILE: tb/tb_segment_box_crossing_test.sv
`timescale 1ns / 1ps

module tb_segment_box_crossing_test;
  import sbct_pkg::*;

  localparam int COORD_BITS = CoordBitsDefault;
  localparam int FRAC_ONE = 1 << 8;
  localparam int RANDOM_QUERIES = 550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [EdgeCount-1:0] HIT_NONE = '0;
  localparam logic [EdgeCount-1:0] HIT_TOP = EdgeCount'(1 << EdgeTop);
  localparam logic [EdgeCount-1:0] HIT_LEFT = EdgeCount'(1 << EdgeLeft);
  localparam logic [EdgeCount-1:0] HIT_BOTTOM = EdgeCount'(1 << EdgeBottom);
  localparam logic [EdgeCount-1:0] HIT_RIGHT = EdgeCount'(1 << EdgeRight);
  localparam logic [EdgeCount-1:0] HIT_ALL = HIT_TOP | HIT_LEFT | HIT_BOTTOM | HIT_RIGHT;

  localparam int C_MAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int C_MIN = -(1 << (COORD_BITS - 1));

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] box_left;
    logic signed [COORD_BITS-1:0] box_top;
    logic        [COORD_BITS-2:0] box_width;
    logic        [COORD_BITS-2:0] box_height;
  } query_t;

  typedef struct packed {
    logic [EdgeCount-1:0] edge_hits;
    logic                 blocked;
  } verdict_t;

  typedef struct packed {
    query_t               query;
    bit                   typed;
    logic [EdgeCount-1:0] hits;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycles = 0;
  int   mismatches = 0;
  int   queries_sent = 0;
  int   results_seen = 0;
  int   blocked_seen = 0;

  verdict_t      verdicts_due[$];
  directed_row_t directed_rows[$];

  sbct_query_if #(.CoordBits(COORD_BITS)) query_bus ();
  sbct_result_if result_bus ();

  segment_box_crossing_test #(.CoordBits(COORD_BITS)) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .query_i (query_bus),
    .result_o(result_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  // Exact parametric test of one segment against one edge; the divisions are
  // folded into comparisons against the positive denominator.
  function automatic bit crosses_edge(input longint x1, input longint y1,
                                      input longint x2, input longint y2,
                                      input longint x3, input longint y3,
                                      input longint x4, input longint y4);
    longint ex, ey, sx, sy, dx, dy, num_a, num_b, den;
    ex = x4 - x3;
    ey = y4 - y3;
    sx = x2 - x1;
    sy = y2 - y1;
    dx = x1 - x3;
    dy = y1 - y3;
    num_a = ex * dy - ey * dx;
    num_b = sx * dy - sy * dx;
    den = ey * sx - ex * sy;
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      num_a = -num_a;
      num_b = -num_b;
    end
    return num_a >= 0 && num_a <= den && num_b >= 0 && num_b <= den;
  endfunction

  function automatic verdict_t predict_crossing(input query_t q);
    longint x1, y1, x2, y2, l, t, r, b;
    verdict_t v;
    x1 = $signed(q.start_x);
    y1 = $signed(q.start_y);
    x2 = $signed(q.end_x);
    y2 = $signed(q.end_y);
    l = $signed(q.box_left);
    t = $signed(q.box_top);
    r = l + longint'(q.box_width);
    b = t - longint'(q.box_height);
    v.edge_hits = HIT_NONE;
    v.edge_hits[EdgeTop] = crosses_edge(x1, y1, x2, y2, l, t, r, t);
    v.edge_hits[EdgeLeft] = crosses_edge(x1, y1, x2, y2, l, t, l, b);
    v.edge_hits[EdgeBottom] = crosses_edge(x1, y1, x2, y2, l, b, r, b);
    v.edge_hits[EdgeRight] = crosses_edge(x1, y1, x2, y2, r, b, r, t);
    v.blocked = |v.edge_hits;
    return v;
  endfunction

  task automatic add_row(input int sx, input int sy, input int ex, input int ey,
                         input int l, input int t, input int w, input int h,
                         input bit typed, input logic [EdgeCount-1:0] hits);
    directed_row_t row;
    row.query.start_x = COORD_BITS'(sx);
    row.query.start_y = COORD_BITS'(sy);
    row.query.end_x = COORD_BITS'(ex);
    row.query.end_y = COORD_BITS'(ey);
    row.query.box_left = COORD_BITS'(l);
    row.query.box_top = COORD_BITS'(t);
    row.query.box_width = (COORD_BITS - 1)'(w);
    row.query.box_height = (COORD_BITS - 1)'(h);
    row.typed = typed;
    row.hits = hits;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Every third stretch of 48 beats runs with no idle cycles at all.
  function automatic int draw_gap(input int beat_index);
    if ((beat_index / 48) % 3 == 1) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Mostly small boxes with segments around them, so that crossings, corner
  // touches and collinear runs are common; the rest is full-range noise.
  function automatic query_t random_query();
    query_t q;
    int kind, span, cx, cy, w, h, x1, y1, x2, y2;
    q.start_x = COORD_BITS'($urandom());
    q.start_y = COORD_BITS'($urandom());
    q.end_x = COORD_BITS'($urandom());
    q.end_y = COORD_BITS'($urandom());
    q.box_left = COORD_BITS'($urandom());
    q.box_top = COORD_BITS'($urandom());
    q.box_width = (COORD_BITS - 1)'($urandom());
    q.box_height = (COORD_BITS - 1)'($urandom());
    kind = $urandom_range(0, 9);
    if (kind < 2) return q;
    span = 1 << $urandom_range(2, (kind == 9) ? 22 : 16);
    cx = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    cy = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    w = $urandom_range(0, span);
    h = $urandom_range(0, span);
    x1 = cx - span + int'($urandom_range(0, 3 * span));
    y1 = cy + span - int'($urandom_range(0, 3 * span));
    x2 = cx - span + int'($urandom_range(0, 3 * span));
    y2 = cy + span - int'($urandom_range(0, 3 * span));
    case (kind)
      7: begin
        if ($urandom_range(0, 1) == 1) begin
          y1 = ($urandom_range(0, 1) == 1) ? cy : cy - h;
          y2 = y1;
        end else begin
          x1 = ($urandom_range(0, 1) == 1) ? cx : cx + w;
          x2 = x1;
        end
      end
      8: begin
        y1 = ($urandom_range(0, 1) == 1) ? cy : cy - h;
        x1 = ($urandom_range(0, 1) == 1) ? cx + int'($urandom_range(0, w))
                                          : (($urandom_range(0, 1) == 1) ? cx : cx + w);
      end
      9: begin
        case ($urandom_range(0, 2))
          0: begin
            x2 = x1;
            y2 = y1;
          end
          1: w = 0;
          default: h = 0;
        endcase
      end
      default: ;
    endcase
    q.start_x = COORD_BITS'(x1);
    q.start_y = COORD_BITS'(y1);
    q.end_x = COORD_BITS'(x2);
    q.end_y = COORD_BITS'(y2);
    q.box_left = COORD_BITS'(cx);
    q.box_top = COORD_BITS'(cy);
    q.box_width = (COORD_BITS - 1)'(w);
    q.box_height = (COORD_BITS - 1)'(h);
    return q;
  endfunction

  // Called at the edge where the previous beat was taken, or right after reset.
  task automatic send_query(input query_t q, input bit typed,
                            input logic [EdgeCount-1:0] hits);
    int gap;
    verdict_t v;
    gap = draw_gap(queries_sent);
    if (gap > 0) begin
      query_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    query_bus.valid <= 1'b1;
    query_bus.start_x <= q.start_x;
    query_bus.start_y <= q.start_y;
    query_bus.end_x <= q.end_x;
    query_bus.end_y <= q.end_y;
    query_bus.box_left <= q.box_left;
    query_bus.box_top <= q.box_top;
    query_bus.box_width <= q.box_width;
    query_bus.box_height <= q.box_height;
    @(posedge clk_i);
    while (!query_bus.ready) @(posedge clk_i);
    if (typed) begin
      v.edge_hits = hits;
      v.blocked = |hits;
    end else begin
      v = predict_crossing(q);
    end
    verdicts_due.insert(verdicts_due.size(), v);
    queries_sent++;
  endtask

  initial begin
    verdict_t v;
    int gap;
    result_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(results_seen + 17);
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_bus.valid) @(posedge clk_i);
      results_seen++;
      if (result_bus.blocked === 1'b1) blocked_seen++;
      if (verdicts_due.size() == 0) begin
        $display("%0t: result beat with nothing expected: edge_hits %b blocked %b",
                 $time, result_bus.edge_hits, result_bus.blocked);
        mismatches++;
      end else begin
        v = verdicts_due.pop_front();
        if (result_bus.edge_hits !== v.edge_hits) begin
          $display("%0t: edge_hits expected %b actual %b",
                   $time, v.edge_hits, result_bus.edge_hits);
          mismatches++;
        end
        if (result_bus.blocked !== v.blocked) begin
          $display("%0t: blocked expected %b actual %b",
                   $time, v.blocked, result_bus.blocked);
          mismatches++;
        end
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    query_bus.valid = 1'b0;
    query_bus.start_x = '0;
    query_bus.start_y = '0;
    query_bus.end_x = '0;
    query_bus.end_y = '0;
    query_bus.box_left = '0;
    query_bus.box_top = '0;
    query_bus.box_width = '0;
    query_bus.box_height = '0;
    rst_ni = 1'b0;

    // Reference box: left 0, top 100, 100 wide and 100 high, so the bottom is at 0.
    add_row(-50 * FRAC_ONE, 50 * FRAC_ONE, 150 * FRAC_ONE, 50 * FRAC_ONE,
            0, 100 * FRAC_ONE, 100 * FRAC_ONE, 100 * FRAC_ONE, 1, HIT_LEFT | HIT_RIGHT);
    add_row(50 * FRAC_ONE, 150 * FRAC_ONE, 50 * FRAC_ONE, -50 * FRAC_ONE,
            0, 100 * FRAC_ONE, 100 * FRAC_ONE, 100 * FRAC_ONE, 1, HIT_TOP | HIT_BOTTOM);
    add_row(20 * FRAC_ONE, 20 * FRAC_ONE, 80 * FRAC_ONE, 80 * FRAC_ONE,
            0, 100 * FRAC_ONE, 100 * FRAC_ONE, 100 * FRAC_ONE, 1, HIT_NONE);
    add_row(200 * FRAC_ONE, 200 * FRAC_ONE, 300 * FRAC_ONE, 300 * FRAC_ONE,
            0, 100 * FRAC_ONE, 100 * FRAC_ONE, 100 * FRAC_ONE, 1, HIT_NONE);
    // A point on the left edge has no direction, so nothing counts.
    add_row(0, 50 * FRAC_ONE, 0, 50 * FRAC_ONE,
            0, 100 * FRAC_ONE, 100 * FRAC_ONE, 100 * FRAC_ONE, 1, HIT_NONE);
    // Boxes squashed to a line keep only the edges that still have length.
    add_row(-50 * FRAC_ONE, 50 * FRAC_ONE, 50 * FRAC_ONE, 50 * FRAC_ONE,
            0, 100 * FRAC_ONE, 0, 100 * FRAC_ONE, 1, HIT_LEFT | HIT_RIGHT);
    add_row(50 * FRAC_ONE, 150 * FRAC_ONE, 50 * FRAC_ONE, 50 * FRAC_ONE,
            0, 100 * FRAC_ONE, 100 * FRAC_ONE, 0, 1, HIT_TOP | HIT_BOTTOM);
    add_row(-50 * FRAC_ONE, 100 * FRAC_ONE, 50 * FRAC_ONE, 100 * FRAC_ONE,
            0, 100 * FRAC_ONE, 0, 0, 1, HIT_NONE);
    // Running along the top edge: the top itself is parallel, the corners touch.
    add_row(-10 * FRAC_ONE, 100 * FRAC_ONE, 200 * FRAC_ONE, 100 * FRAC_ONE,
            0, 100 * FRAC_ONE, 100 * FRAC_ONE, 100 * FRAC_ONE, 1, HIT_LEFT | HIT_RIGHT);
    add_row(-50 * FRAC_ONE, 150 * FRAC_ONE, 0, 100 * FRAC_ONE,
            0, 100 * FRAC_ONE, 100 * FRAC_ONE, 100 * FRAC_ONE, 1, HIT_TOP | HIT_LEFT);
    add_row(50 * FRAC_ONE, -50 * FRAC_ONE, 50 * FRAC_ONE, 0,
            0, 100 * FRAC_ONE, 100 * FRAC_ONE, 100 * FRAC_ONE, 1, HIT_BOTTOM);
    add_row(-10 * FRAC_ONE, 110 * FRAC_ONE, 110 * FRAC_ONE, -10 * FRAC_ONE,
            0, 100 * FRAC_ONE, 100 * FRAC_ONE, 100 * FRAC_ONE, 1, HIT_ALL);
    add_row(-10 * FRAC_ONE, 120 * FRAC_ONE, 120 * FRAC_ONE, -10 * FRAC_ONE,
            0, 100 * FRAC_ONE, 100 * FRAC_ONE, 100 * FRAC_ONE, 1, HIT_TOP | HIT_RIGHT);
    add_row(C_MIN, 0, C_MAX, 0, -100, 100, 200, 200, 1, HIT_LEFT | HIT_RIGHT);
    add_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1, HIT_NONE);
    add_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 0, 0, 1, HIT_NONE);
    add_row(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, 0, HIT_NONE);
    add_row(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0, HIT_NONE);
    add_row(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, 0, HIT_NONE);
    add_row(C_MIN, C_MAX, C_MAX, C_MIN, 0, -1, C_MAX, C_MAX, 0, HIT_NONE);
    add_row('h555555, 'haaaaaa, 'haaaaaa, 'h555555, 'h555555, 'haaaaaa,
            'h2aaaaa, 'h555555, 0, HIT_NONE);
    add_row('haaaaaa, 'h555555, 'h555555, 'haaaaaa, 'haaaaaa, 'h555555,
            'h555555, 'h2aaaaa, 0, HIT_NONE);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_query(directed_rows[i].query, directed_rows[i].typed, directed_rows[i].hits);
    end
    repeat (RANDOM_QUERIES) begin
      send_query(random_query(), 1'b0, HIT_NONE);
    end
    query_bus.valid <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d queries (%0d from the directed table), checked %0d results.",
             queries_sent, directed_rows.size(), results_seen);
    $display("Segments crossing the box: %0d, clear of it: %0d; mismatches: %0d.",
             blocked_seen, results_seen - blocked_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
